@@ rtl/mspr_pkg.sv @@
// Shared types, codes and defaults of the multi-stage ring pointers unit.
package mspr_pkg;

    localparam int DEF_MAX_STAGES   = 8;
    localparam int DEF_COUNTER_BITS = 8;
    localparam int N_W              = 5;

    localparam logic [1:0] CMD_QUERY   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] CFG_SLOT_LOG2  = 2'd0;
    localparam logic [1:0] CFG_NUM_STAGES = 2'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] stage;
    } t_cmd;

    typedef struct packed {
        logic [6:0] slot_index;
        logic [7:0] available;
        logic       slot_valid;
        logic       moved;
        logic       stage_error;
    } t_res;

    typedef struct packed {
        logic [1:0] index;
        logic [3:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] stage;
        logic       err;
    } t_op;

    typedef struct packed {
        logic [2:0]     slot_count_log2;
        logic [N_W-1:0] eff_stages;
    } t_view;

endpackage

@@ rtl/mspr_chan.sv @@
// Valid/ready channel carrying one request payload.
interface mspr_chan #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mspr_queue.sv @@
// Two-entry queue between the front and back parts.
module mspr_queue #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_data,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_data
);
    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end
endmodule

@@ rtl/mspr_front.sv @@
// Front part: configuration registers and request classification.
module mspr_front import mspr_pkg::*; #(
    parameter int MAX_STAGES = DEF_MAX_STAGES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mspr_chan.sink i_cmd,
    mspr_chan.sink i_cfg,
    input  logic  i_push_ready,
    output logic  o_push_valid,
    output t_op   o_op,
    output t_view o_view
);
    logic [2:0]     r_slot_log2;
    logic [3:0]     r_num_stages;
    logic [N_W-1:0] eff_stages;

    assign i_cfg.ready  = 1'b1;
    assign i_cmd.ready  = i_push_ready;
    assign o_push_valid = i_cmd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_log2  <= 3'd3;
            r_num_stages <= 4'd2;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_SLOT_LOG2:  r_slot_log2 <= i_cfg.data.value[2:0];
                CFG_NUM_STAGES: r_num_stages <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_num_stages < 4'd2) begin
            eff_stages = N_W'(2);
        end else if ({1'b0, r_num_stages} > N_W'(MAX_STAGES)) begin
            eff_stages = N_W'(MAX_STAGES);
        end else begin
            eff_stages = {1'b0, r_num_stages};
        end

        unique case (i_cmd.data.command)
            CMD_ADVANCE: o_op.command = CMD_ADVANCE;
            CMD_CLEAR:   o_op.command = CMD_CLEAR;
            default:     o_op.command = CMD_QUERY;
        endcase
        o_op.stage = i_cmd.data.stage;
        o_op.err   = (N_W'(i_cmd.data.stage) >= eff_stages);

        o_view.slot_count_log2 = r_slot_log2;
        o_view.eff_stages      = eff_stages;
    end
endmodule

@@ rtl/mspr_back.sv @@
// Back part: stage counters, result computation and output register.
module mspr_back import mspr_pkg::*; #(
    parameter int MAX_STAGES   = DEF_MAX_STAGES,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_op_valid,
    output logic  o_op_ready,
    input  t_op   i_op,
    input  t_view i_view,
    mspr_chan.source o_res
);
    localparam int SIDX_W = $clog2(MAX_STAGES);

    logic [COUNTER_BITS-1:0] r_cnt [MAX_STAGES];
    logic [COUNTER_BITS-1:0] lane_av [MAX_STAGES];
    logic [COUNTER_BITS-1:0] cnt_last;
    logic [COUNTER_BITS-1:0] cur_cnt;
    logic [COUNTER_BITS-1:0] cur_av;
    logic [COUNTER_BITS-1:0] slots_c;
    logic [SIDX_W-1:0]       last_idx;
    logic [SIDX_W-1:0]       sel;
    logic [15:0]             slots16;
    logic [15:0]             idx16;
    logic [15:0]             av16;
    logic                    do_move;
    logic                    pop;
    t_res                    res;
    t_res                    r_res;
    logic                    r_res_valid;

    for (genvar k = 0; k < MAX_STAGES; k++) begin : g_lane
        if (k == 0) begin : g_first
            assign lane_av[k] = cnt_last + slots_c - r_cnt[0];
        end else begin : g_next
            assign lane_av[k] = r_cnt[k-1] - r_cnt[k];
        end
    end

    always_comb begin
        slots16  = 16'd1 << i_view.slot_count_log2;
        slots_c  = COUNTER_BITS'(slots16);
        last_idx = SIDX_W'(i_view.eff_stages - N_W'(1));
        cnt_last = '0;
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (SIDX_W'(k) == last_idx) begin
                cnt_last = r_cnt[k];
            end
        end
    end

    always_comb begin
        sel     = SIDX_W'(i_op.stage);
        cur_cnt = '0;
        cur_av  = '0;
        for (int k = 0; k < MAX_STAGES; k++) begin
            if (SIDX_W'(k) == sel) begin
                cur_cnt = r_cnt[k];
                cur_av  = lane_av[k];
            end
        end
        idx16   = 16'(cur_cnt) & (slots16 - 16'd1);
        av16    = 16'(cur_av);
        do_move = !i_op.err && (i_op.command == CMD_ADVANCE) && (cur_av != '0);

        res.slot_index  = i_op.err ? 7'd0 : idx16[6:0];
        res.available   = i_op.err ? 8'd0 : av16[7:0];
        res.slot_valid  = !i_op.err && (av16[7:0] != 8'd0);
        res.moved       = do_move;
        res.stage_error = i_op.err;
    end

    assign o_op_ready  = !r_res_valid || o_res.ready;
    assign pop         = i_op_valid && o_op_ready;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_STAGES; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (pop && !i_op.err) begin
            for (int k = 0; k < MAX_STAGES; k++) begin
                if (i_op.command == CMD_CLEAR) begin
                    r_cnt[k] <= '0;
                end else if (do_move && (SIDX_W'(k) == sel)) begin
                    r_cnt[k] <= cur_cnt + COUNTER_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (pop) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res <= res;
        end
    end
endmodule

@@ rtl/multi_stage_ring_pointers_unit.sv @@
// Multi-stage ring pointers unit: top level joining front, queue and back.
// An accepted request waits in the two-entry queue, executes when the back part pops it, and its result is registered.
// Throughput: one request per cycle; a held result stalls the back part, and the input stalls
// once the two-entry queue is full.
// Reset: synchronous, active low; clears the stage counters, queue and result valid flag, and sets
// the slot count exponent to 3 and the stage count register to 2.
module multi_stage_ring_pointers_unit import mspr_pkg::*; #(
    parameter int MAX_STAGES   = DEF_MAX_STAGES,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mspr_chan.sink   i_cmd,
    mspr_chan.sink   i_cfg,
    mspr_chan.source o_res
);
    logic  push_valid;
    logic  push_ready;
    t_op   push_op;
    logic  op_valid;
    logic  op_ready;
    t_op   op;
    t_view view;

    mspr_front #(
        .MAX_STAGES (MAX_STAGES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_cfg        (i_cfg),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_op         (push_op),
        .o_view       (view)
    );

    mspr_queue #(
        .t_item (t_op)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_op),
        .o_pop_valid  (op_valid),
        .i_pop_ready  (op_ready),
        .o_pop_data   (op)
    );

    mspr_back #(
        .MAX_STAGES   (MAX_STAGES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .i_op       (op),
        .i_view     (view),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.stage_error) |->
            (o_res.data.slot_index == 7'd0 && o_res.data.available == 8'd0 &&
             !o_res.data.moved && !o_res.data.slot_valid))
        else $error("stage error result carries nonzero fields");

    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.slot_valid == (o_res.data.available != 8'd0)))
        else $error("slot_valid disagrees with available");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.data)))
        else $error("pending result changed while stalled");
`endif
endmodule

@@ sim/mspr_ring_checker.sv @@
// Checker for the ring pointers unit: tracks stage counters, predicts each result and compares.
`timescale 1ns / 100ps
module mspr_ring_checker import mspr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  logic    i_cmd_ready,
    input  t_cmd    i_cmd_data,
    input  logic    i_cfg_valid,
    input  logic    i_cfg_ready,
    input  t_cfg_wr i_cfg_data,
    input  logic    i_res_valid,
    input  logic    i_res_ready,
    input  t_res    i_res_data,
    output int      o_errors,
    output int      o_pending
);
    logic [7:0] stage_ptr [DEF_MAX_STAGES];
    logic [2:0] ring_log2;
    logic [3:0] stage_num;
    t_res       res_expected [$];
    int         errors;

    assign o_errors = errors;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic t_res ring_step(input t_cmd req);
        t_res       res;
        logic [3:0] live;
        logic [7:0] slots;
        logic [7:0] avail;
        res = '0;
        if (stage_num < 4'd2) begin
            live = 4'd2;
        end else if (stage_num > 4'(DEF_MAX_STAGES)) begin
            live = 4'(DEF_MAX_STAGES);
        end else begin
            live = stage_num;
        end
        slots = 8'd1 << ring_log2;
        if (4'(req.stage) >= live) begin
            res.stage_error = 1'b1;
        end else begin
            if (req.stage == 3'd0) begin
                avail = stage_ptr[live - 4'd1] + slots - stage_ptr[0];
            end else begin
                avail = stage_ptr[req.stage - 3'd1] - stage_ptr[req.stage];
            end
            res.slot_index = 7'(stage_ptr[req.stage] & (slots - 8'd1));
            res.available  = avail;
            res.slot_valid = (avail != 8'd0);
            if (req.command == CMD_ADVANCE && avail != 8'd0) begin
                stage_ptr[req.stage] = stage_ptr[req.stage] + 8'd1;
                res.moved = 1'b1;
            end else if (req.command == CMD_CLEAR) begin
                foreach (stage_ptr[i]) stage_ptr[i] = '0;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            foreach (stage_ptr[i]) stage_ptr[i] = '0;
            ring_log2 = 3'd3;
            stage_num = 4'd2;
            res_expected.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (res_expected.size() == 0) begin
                    report_mismatch($sformatf("result %h with none expected", i_res_data));
                end else begin
                    want = res_expected.pop_front();
                    check_field("slot_index", 8'(i_res_data.slot_index), 8'(want.slot_index));
                    check_field("available", i_res_data.available, want.available);
                    check_field("slot_valid", 8'(i_res_data.slot_valid), 8'(want.slot_valid));
                    check_field("moved", 8'(i_res_data.moved), 8'(want.moved));
                    check_field("stage_error", 8'(i_res_data.stage_error),
                                8'(want.stage_error));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    CFG_SLOT_LOG2: begin
                        ring_log2 = i_cfg_data.value[2:0];
                    end
                    CFG_NUM_STAGES: begin
                        stage_num = i_cfg_data.value;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd_valid && i_cmd_ready) begin
                res_expected.push_back(ring_step(i_cmd_data));
            end
        end
        o_pending <= res_expected.size();
    end

endmodule

@@ sim/multi_stage_ring_pointers_unit_tb.sv @@
// Testbench top for the ring pointers unit: drives requests and settings, gives the verdict.
`timescale 1ns / 100ps
module multi_stage_ring_pointers_unit_tb;
    import mspr_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         GAP_PCT     = 22;
    localparam int         STALL_PCT   = 35;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         SETTLE      = 8;
    localparam int         PHASE_ITEMS = 100;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   quiet_cycles = 0;
    int   live_stages;
    bit   steady = 1'b0;

    mspr_chan #(.t_payload(t_cmd))    cmd_if ();
    mspr_chan #(.t_payload(t_cfg_wr)) cfg_if ();
    mspr_chan #(.t_payload(t_res))    res_if ();

    multi_stage_ring_pointers_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    mspr_ring_checker ring_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_if.valid),
        .i_cmd_ready (cmd_if.ready),
        .i_cmd_data  (cmd_if.data),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg_data  (cfg_if.data),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res_data  (res_if.data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multi_stage_ring_pointers_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input t_cmd req);
        if (!steady && $urandom_range(99) < GAP_PCT) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= req;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    task automatic issue(input logic [1:0] command, input logic [2:0] stage);
        t_cmd req;
        req.command = command;
        req.stage   = stage;
        send_request(req);
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic configure(input int log2, input int stages);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: CFG_SLOT_LOG2, value: 4'(log2)};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.data  <= '{index: CFG_NUM_STAGES, value: 4'(stages)};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        if (stages < 2) begin
            live_stages = 2;
        end else if (stages > DEF_MAX_STAGES) begin
            live_stages = DEF_MAX_STAGES;
        end else begin
            live_stages = stages;
        end
    endtask

    function automatic t_cmd random_request();
        t_cmd req;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            req.command = CMD_ADVANCE;
        end else if (pick < 90) begin
            req.command = CMD_QUERY;
        end else if (pick < 95) begin
            req.command = CMD_UNUSED;
        end else begin
            req.command = CMD_CLEAR;
        end
        if ($urandom_range(99) < 85) begin
            req.stage = 3'($urandom_range(live_stages - 1));
        end else begin
            req.stage = 3'($urandom_range(7));
        end
        return req;
    endfunction

    task automatic run_phase(input int log2, input int stages);
        configure(log2, stages);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) begin
                drain_results();
            end
            send_request(random_request());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        live_stages  = 2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(CMD_QUERY, 3'd0);
        issue(CMD_QUERY, 3'd1);
        issue(CMD_ADVANCE, 3'd1);
        repeat (9) issue(CMD_ADVANCE, 3'd0);
        issue(CMD_ADVANCE, 3'd1);
        issue(CMD_UNUSED, 3'd1);
        issue(CMD_QUERY, 3'd2);
        issue(CMD_ADVANCE, 3'd7);
        issue(CMD_CLEAR, 3'd5);
        issue(CMD_QUERY, 3'd0);
        issue(CMD_CLEAR, 3'd1);
        issue(CMD_QUERY, 3'd0);

        run_phase(0, 0);
        run_phase(7, 8);
        steady <= 1'b1;
        run_phase(0, 15);
        steady <= 1'b0;
        run_phase(7, 1);
        run_phase(5, 3);
        run_phase(1, 8);
        run_phase(6, 12);
        run_phase($urandom_range(7), $urandom_range(15));

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("multi_stage_ring_pointers_unit verification clean");
        end else begin
            $display("multi_stage_ring_pointers_unit verification failed");
        end
        $finish;
    end

endmodule
